/* rtl/core/tmse_pkg.sv */
// Shared types, codes and constants for the Turing machine step engine.
package tmse_pkg;

    localparam int RULE_DEPTH_DEF = 64;
    localparam int TAPE_DEPTH_DEF = 256;
    localparam logic [7:0] BLANK_CELL = 8'd48;
    localparam logic [7:0] HALT_RESET = 8'd255;
    localparam logic [7:0] WILD_RESET = 8'd95;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [0:0] CFG_HALT = 1'b0;
    localparam logic [0:0] CFG_WILD = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HALTED   = 3'd1;
    localparam logic [2:0] ST_NO_RULES = 3'd2;
    localparam logic [2:0] ST_NO_MATCH = 3'd3;
    localparam logic [2:0] ST_HEAD_OUT = 3'd4;
    localparam logic [2:0] ST_DUP      = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;
    localparam logic [2:0] ST_FAULTED  = 3'd7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        rule_state;
        logic [7:0]        read_symbol;
        logic [7:0]        write_symbol;
        logic signed [3:0] move_steps;
        logic [7:0]        nxt_state;
        logic [7:0]        cell_address;
        logic [7:0]        cell_symbol;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cur_state;
        logic [7:0] head_position;
        logic [7:0] cell_value;
        logic       halted;
    } t_out_word;

    typedef struct packed {
        logic [7:0]        st;
        logic [7:0]        rd;
        logic [7:0]        wr;
        logic signed [3:0] mv;
        logic [7:0]        nx;
    } t_rule;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_TAPE_RD, S_TAPE_WAIT, S_SCAN_RD, S_SCAN_CHK,
        S_ADD_STORE, S_FIRE, S_CELL_RD, S_CELL_WAIT, S_DONE
    } t_state;

endpackage

/* rtl/core/turing_machine_step_engine_top.sv */
// Top level: sequenced rule-table Turing machine with tape and rule memories.
// Each word ends in the cell read states. A tape read or write goes there straight; so does a
// step stopped by a fault, an empty table or a halt. Add rule and step scan the rule table
// in order, each rule a registered rule read, then a compare; an add stops at a duplicate.
// A step first reads the cell under the head. One word at a time: busy drops in the cycle the
// result shows, so the next start can be taken while the result shows. After reset a clearing
// pass fills the tape with '0' (busy high). Each result shows for one cycle with o_done; no receiver stall.
module turing_machine_step_engine_top #(
    parameter int RULE_DEPTH = tmse_pkg::RULE_DEPTH_DEF,
    parameter int TAPE_DEPTH = tmse_pkg::TAPE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tmse_pkg::t_in_word  i_word,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    output logic                o_done,
    output tmse_pkg::t_out_word o_word
);
    localparam int RA = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int RC = $clog2(RULE_DEPTH + 1);
    localparam int TA = $clog2(TAPE_DEPTH);
    localparam int TC = TA + 1;
    localparam int PW = TA + 2;
    localparam int AW = ((TA > 8) ? TA : 8) + 1;

    tmse_pkg::t_rule r_rules [RULE_DEPTH];
    logic [7:0]      r_tape  [TAPE_DEPTH];

    tmse_pkg::t_state r_st, n_st;
    tmse_pkg::t_in_word r_in, n_in;
    tmse_pkg::t_out_word r_out, n_out;
    tmse_pkg::t_rule r_rq;
    logic [7:0] r_tq;
    logic [RC-1:0] r_cnt, n_cnt;
    logic [RC-1:0] r_idx, n_idx;
    logic [TA-1:0] r_head, n_head;
    logic [7:0] r_mst, n_mst, r_halt, r_wild;
    logic [2:0] r_fault, n_fault, r_stat, n_stat;
    logic [7:0] r_under, n_under;
    logic [TC-1:0] r_clr, n_clr;
    logic r_done, n_done;
    tmse_pkg::t_rule r_hit, n_hit;

    logic          rule_we;
    logic [RA-1:0] rule_ra;
    logic          tape_we;
    logic [TA-1:0] tape_wa, tape_ra;
    logic [7:0]    tape_wd;
    logic          addr_ok;
    logic [AW-1:0] cell_ext;
    logic signed [PW-1:0] pos;

    assign cell_ext = AW'(r_in.cell_address);
    assign addr_ok = (cell_ext < AW'(TAPE_DEPTH));
    assign pos = $signed({2'b00, r_head}) + PW'(r_hit.mv);

    always_ff @(posedge i_clk) begin
        if (rule_we) r_rules[r_cnt[RA-1:0]] <= '{r_in.rule_state, r_in.read_symbol,
            r_in.write_symbol, r_in.move_steps, r_in.nxt_state};
        r_rq <= r_rules[rule_ra];
        if (tape_we) r_tape[tape_wa] <= tape_wd;
        r_tq <= r_tape[tape_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tmse_pkg::S_CLEAR; r_cnt <= '0; r_head <= '0; r_mst <= '0;
            r_fault <= '0; r_clr <= '0; r_done <= 1'b0;
            r_halt <= tmse_pkg::HALT_RESET; r_wild <= tmse_pkg::WILD_RESET;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_head <= n_head; r_mst <= n_mst;
            r_fault <= n_fault; r_clr <= n_clr; r_done <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tmse_pkg::CFG_HALT: r_halt <= i_cfg_data;
                    tmse_pkg::CFG_WILD: r_wild <= i_cfg_data;
                endcase
            end
        end
        r_in <= n_in; r_out <= n_out; r_idx <= n_idx; r_stat <= n_stat;
        r_under <= n_under; r_hit <= n_hit;
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_head = r_head; n_mst = r_mst;
        n_fault = r_fault; n_clr = r_clr; n_done = 1'b0; n_in = r_in;
        n_out = r_out; n_idx = r_idx; n_stat = r_stat; n_under = r_under;
        n_hit = r_hit;
        rule_we = 1'b0; rule_ra = r_idx[RA-1:0];
        tape_we = 1'b0; tape_wa = r_head; tape_wd = r_hit.wr; tape_ra = r_head;
        unique case (r_st)
            tmse_pkg::S_CLEAR: begin
                tape_we = 1'b1; tape_wa = r_clr[TA-1:0]; tape_wd = tmse_pkg::BLANK_CELL;
                n_clr = r_clr + 1'b1;
                if (r_clr == TC'(TAPE_DEPTH - 1)) n_st = tmse_pkg::S_IDLE;
            end
            tmse_pkg::S_IDLE: begin
                if (start) begin
                    n_in = i_word; n_idx = '0; n_stat = tmse_pkg::ST_OK;
                    unique case (i_word.kind)
                        tmse_pkg::KIND_ADD:   n_st = tmse_pkg::S_SCAN_RD;
                        tmse_pkg::KIND_STEP: begin
                            if (r_fault != 3'd0) begin
                                n_stat = tmse_pkg::ST_FAULTED; n_st = tmse_pkg::S_CELL_RD;
                            end else if (r_cnt == '0) begin
                                n_stat = tmse_pkg::ST_NO_RULES; n_fault = tmse_pkg::ST_NO_RULES;
                                n_st = tmse_pkg::S_CELL_RD;
                            end else if (r_mst == r_halt) begin
                                n_stat = tmse_pkg::ST_HALTED; n_st = tmse_pkg::S_CELL_RD;
                            end else n_st = tmse_pkg::S_TAPE_RD;
                        end
                        default: n_st = tmse_pkg::S_CELL_RD;
                    endcase
                end
            end
            tmse_pkg::S_TAPE_RD: n_st = tmse_pkg::S_TAPE_WAIT;
            tmse_pkg::S_TAPE_WAIT: begin
                n_under = r_tq; n_st = tmse_pkg::S_SCAN_RD;
            end
            tmse_pkg::S_SCAN_RD: begin
                // rule read issued at r_idx; past the count the scan ends
                if (r_idx == r_cnt) begin
                    if (r_in.kind == tmse_pkg::KIND_ADD) n_st = tmse_pkg::S_ADD_STORE;
                    else begin
                        n_stat = tmse_pkg::ST_NO_MATCH; n_fault = tmse_pkg::ST_NO_MATCH;
                        n_st = tmse_pkg::S_CELL_RD;
                    end
                end else n_st = tmse_pkg::S_SCAN_CHK;
            end
            tmse_pkg::S_SCAN_CHK: begin
                n_idx = r_idx + 1'b1; n_st = tmse_pkg::S_SCAN_RD; n_hit = r_rq;
                if (r_in.kind == tmse_pkg::KIND_ADD) begin
                    if (r_rq.st == r_in.rule_state && r_rq.rd == r_in.read_symbol) begin
                        n_stat = tmse_pkg::ST_DUP; n_st = tmse_pkg::S_CELL_RD;
                    end
                end else if (r_rq.st == r_mst && (r_rq.rd == r_under || r_rq.rd == r_wild))
                    n_st = tmse_pkg::S_FIRE;
            end
            tmse_pkg::S_ADD_STORE: begin
                if (r_cnt == RC'(RULE_DEPTH)) n_stat = tmse_pkg::ST_FULL;
                else begin
                    rule_we = 1'b1; n_cnt = r_cnt + 1'b1;
                    if (r_cnt == '0) n_mst = r_in.rule_state;
                end
                n_st = tmse_pkg::S_CELL_RD;
            end
            tmse_pkg::S_FIRE: begin
                tape_we = (r_hit.wr != r_wild);
                if (pos < 0 || pos >= PW'(TAPE_DEPTH)) begin
                    n_stat = tmse_pkg::ST_HEAD_OUT; n_fault = tmse_pkg::ST_HEAD_OUT;
                end else begin
                    n_head = pos[TA-1:0]; n_mst = r_hit.nx;
                end
                n_st = tmse_pkg::S_CELL_RD;
            end
            tmse_pkg::S_CELL_RD: begin
                if (r_in.kind == tmse_pkg::KIND_WRITE || r_in.kind == tmse_pkg::KIND_READ) begin
                    tape_ra = cell_ext[TA-1:0];
                    tape_wa = cell_ext[TA-1:0]; tape_wd = r_in.cell_symbol;
                    tape_we = (r_in.kind == tmse_pkg::KIND_WRITE) && addr_ok;
                end
                n_st = tmse_pkg::S_CELL_WAIT;
            end
            tmse_pkg::S_CELL_WAIT: begin
                // second read picks up a tape write done on the previous edge
                if (r_in.kind == tmse_pkg::KIND_WRITE || r_in.kind == tmse_pkg::KIND_READ)
                    tape_ra = cell_ext[TA-1:0];
                n_st = tmse_pkg::S_DONE;
            end
            tmse_pkg::S_DONE: begin
                n_out.status = r_stat; n_out.cur_state = r_mst;
                n_out.head_position = 8'(r_head);
                n_out.cell_value = r_tq;
                if ((r_in.kind == tmse_pkg::KIND_WRITE || r_in.kind == tmse_pkg::KIND_READ)
                    && !addr_ok) n_out.cell_value = 8'd0;
                n_out.halted = (r_mst == r_halt);
                n_done = 1'b1; n_st = tmse_pkg::S_IDLE;
            end
            default: n_st = tmse_pkg::S_IDLE;
        endcase
    end

    assign busy = (r_st != tmse_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_word = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RC'(RULE_DEPTH)) else $error("rule count past depth");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_fault) != 3'd0 && $past(i_rst_n) |-> $stable(r_fault))
        else $error("fault changed");
endmodule

/* bench/testbench.sv */
// Testbench for the Turing machine step engine: directed table, then random words vs a predictor.
module testbench;

    localparam int RULES = tmse_pkg::RULE_DEPTH_DEF;
    localparam int CELLS = tmse_pkg::TAPE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 6000;
    localparam int IN_W = $bits(tmse_pkg::t_in_word);

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    tmse_pkg::t_in_word  i_word;
    logic      i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic      o_done;
    tmse_pkg::t_out_word o_word;

    turing_machine_step_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_word(i_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_word(o_word)
    );

    // shadow machine
    tmse_pkg::t_rule rules [RULES];
    int         rule_cnt;
    logic [7:0] tape [CELLS];
    int         head;
    logic [7:0] mstate;
    logic [2:0] fault;
    logic [7:0] halt_reg;
    logic [7:0] wild_reg;

    tmse_pkg::t_out_word pending_words [$];
    int         mismatches;
    int         idle_cycles;
    bit         no_gaps;
    bit         allow_fault;

    typedef struct {
        tmse_pkg::t_in_word  w;
        bit                  typed;
        tmse_pkg::t_out_word ex;
    } t_row;
    t_row rows [$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [2:0] shadow_add(input tmse_pkg::t_in_word w);
        for (int i = 0; i < rule_cnt; i++)
            if (rules[i].st == w.rule_state && rules[i].rd == w.read_symbol)
                return tmse_pkg::ST_DUP;
        if (rule_cnt >= RULES) return tmse_pkg::ST_FULL;
        rules[rule_cnt] = '{st: w.rule_state, rd: w.read_symbol, wr: w.write_symbol,
                            mv: w.move_steps, nx: w.nxt_state};
        if (rule_cnt == 0) mstate = w.rule_state;
        rule_cnt++;
        return tmse_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] fire_step();
        int pos;
        if (fault != tmse_pkg::ST_OK) return tmse_pkg::ST_FAULTED;
        if (rule_cnt == 0) begin
            fault = tmse_pkg::ST_NO_RULES;
            return tmse_pkg::ST_NO_RULES;
        end
        if (mstate == halt_reg) return tmse_pkg::ST_HALTED;
        for (int i = 0; i < rule_cnt; i++) begin
            if (rules[i].st == mstate &&
                (rules[i].rd == tape[head] || rules[i].rd == wild_reg)) begin
                if (rules[i].wr != wild_reg) tape[head] = rules[i].wr;
                pos = head + int'(rules[i].mv);
                if (pos < 0 || pos >= CELLS) begin
                    fault = tmse_pkg::ST_HEAD_OUT;
                    return tmse_pkg::ST_HEAD_OUT;
                end
                head = pos;
                mstate = rules[i].nx;
                return tmse_pkg::ST_OK;
            end
        end
        fault = tmse_pkg::ST_NO_MATCH;
        return tmse_pkg::ST_NO_MATCH;
    endfunction

    // would a step now raise a new fault
    function automatic bit step_faults();
        int pos;
        if (fault != tmse_pkg::ST_OK) return 1'b0;
        if (rule_cnt == 0) return 1'b1;
        if (mstate == halt_reg) return 1'b0;
        for (int i = 0; i < rule_cnt; i++) begin
            if (rules[i].st == mstate &&
                (rules[i].rd == tape[head] || rules[i].rd == wild_reg)) begin
                pos = head + int'(rules[i].mv);
                return (pos < 0 || pos >= CELLS);
            end
        end
        return 1'b1;
    endfunction

    function automatic tmse_pkg::t_out_word predict_word(input tmse_pkg::t_in_word w);
        tmse_pkg::t_out_word r;
        logic [2:0] st;
        logic [7:0] cval;
        st = tmse_pkg::ST_OK;
        case (w.kind)
            tmse_pkg::KIND_ADD: begin
                st = shadow_add(w);
                cval = tape[head];
            end
            tmse_pkg::KIND_WRITE: begin
                if (int'(w.cell_address) < CELLS) begin
                    tape[w.cell_address] = w.cell_symbol;
                    cval = tape[w.cell_address];
                end else cval = 8'd0;
            end
            tmse_pkg::KIND_STEP: begin
                st = fire_step();
                cval = tape[head];
            end
            default: cval = (int'(w.cell_address) < CELLS) ? tape[w.cell_address] : 8'd0;
        endcase
        r.status = st;
        r.cur_state = mstate;
        r.head_position = head[7:0];
        r.cell_value = cval;
        r.halted = (mstate == halt_reg);
        return r;
    endfunction

    task automatic send_word(input tmse_pkg::t_in_word w, input bit typed,
                             input tmse_pkg::t_out_word ex);
        int gap;
        tmse_pkg::t_out_word pr;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        pr = predict_word(w);
        pending_words.push_back(typed ? ex : pr);
    endtask

    // sender holds off until every result is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tmse_pkg::CFG_HALT) halt_reg = val;
        else wild_reg = val;
        @(posedge i_clk);
    endtask

    function automatic tmse_pkg::t_in_word rand_word();
        tmse_pkg::t_in_word w;
        int pick;
        w = tmse_pkg::t_in_word'(IN_W'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 15) w.kind = tmse_pkg::KIND_ADD;
        else if (pick < 35) w.kind = tmse_pkg::KIND_WRITE;
        else if (pick < 80) w.kind = tmse_pkg::KIND_STEP;
        else w.kind = tmse_pkg::KIND_READ;
        if ($urandom_range(0, 3) != 0) w.rule_state = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 3) != 0) w.nxt_state = 8'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 4) w.read_symbol = wild_reg;
        else if (pick < 6) w.read_symbol = tmse_pkg::BLANK_CELL;
        else if (pick < 8) w.read_symbol = 8'($urandom_range(48, 51));
        if ($urandom_range(0, 3) == 0) w.write_symbol = wild_reg;
        else if ($urandom_range(0, 1) == 0) w.write_symbol = 8'($urandom_range(48, 51));
        if ($urandom_range(0, 2) != 0) w.cell_address = 8'(head + $urandom_range(0, 15) - 8);
        if ($urandom_range(0, 1) == 0) w.cell_symbol = 8'($urandom_range(48, 51));
        return w;
    endfunction

    function automatic tmse_pkg::t_in_word mk(input logic [1:0] k, input logic [7:0] st,
                                    input logic [7:0] rd, input logic [7:0] wr,
                                    input logic signed [3:0] mv, input logic [7:0] nx,
                                    input logic [7:0] addr, input logic [7:0] sym);
        tmse_pkg::t_in_word w;
        w = '{kind: k, rule_state: st, read_symbol: rd, write_symbol: wr, move_steps: mv,
              nxt_state: nx, cell_address: addr, cell_symbol: sym};
        return w;
    endfunction

    function automatic tmse_pkg::t_out_word ow(input logic [2:0] s, input logic [7:0] c,
                                     input logic [7:0] h, input logic [7:0] v, input logic hl);
        tmse_pkg::t_out_word r;
        r = '{status: s, cur_state: c, head_position: h, cell_value: v, halted: hl};
        return r;
    endfunction

    task automatic add_row(input tmse_pkg::t_in_word w);
        rows.push_back('{w: w, typed: 1'b0, ex: '0});
    endtask

    task automatic add_typed(input tmse_pkg::t_in_word w, input tmse_pkg::t_out_word ex);
        rows.push_back('{w: w, typed: 1'b1, ex: ex});
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_word);
            end else begin
                if (o_word !== pending_words[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word mismatch: exp st=%0d cs=%0d hd=%0d cv=%0d h=%0d",
                                 pending_words[0].status, pending_words[0].cur_state,
                                 pending_words[0].head_position, pending_words[0].cell_value,
                                 pending_words[0].halted);
                        $display("               got st=%0d cs=%0d hd=%0d cv=%0d h=%0d",
                                 o_word.status, o_word.cur_state, o_word.head_position,
                                 o_word.cell_value, o_word.halted);
                    end
                end
                void'(pending_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("turing_machine_step_engine_top: mismatch");
            $finish;
        end
    end

    initial begin
        tmse_pkg::t_in_word w;
        logic [7:0] halt_vals [8];
        logic [7:0] wild_vals [8];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tmse_pkg::CFG_HALT;
        i_cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        allow_fault = 1'b0;
        rule_cnt = 0;
        head = 0;
        mstate = '0;
        fault = tmse_pkg::ST_OK;
        halt_reg = tmse_pkg::HALT_RESET;
        wild_reg = tmse_pkg::WILD_RESET;
        foreach (tape[i]) tape[i] = tmse_pkg::BLANK_CELL;
        foreach (rules[i]) rules[i] = '0;

        // directed words; machine walks 0 -> 1 -> 2 -> 0 with extreme moves
        add_typed(mk(tmse_pkg::KIND_READ, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'd0, 8'h00),
                  ow(tmse_pkg::ST_OK, 8'd0, 8'd0, tmse_pkg::BLANK_CELL, 1'b0));
        add_typed(mk(tmse_pkg::KIND_WRITE, 8'hff, 8'hff, 8'hff, -4'sd1, 8'hff, 8'd255, 8'hff),
                  ow(tmse_pkg::ST_OK, 8'd0, 8'd0, 8'hff, 1'b0));
        add_typed(mk(tmse_pkg::KIND_READ, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'd255, 8'h00),
                  ow(tmse_pkg::ST_OK, 8'd0, 8'd0, 8'hff, 1'b0));
        add_typed(mk(tmse_pkg::KIND_WRITE, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'd0, 8'h00),
                  ow(tmse_pkg::ST_OK, 8'd0, 8'd0, 8'h00, 1'b0));
        add_row(mk(tmse_pkg::KIND_ADD, 8'd0, tmse_pkg::WILD_RESET, 8'd49, 4'sd1, 8'd1,
                   8'h00, 8'h00));
        add_typed(mk(tmse_pkg::KIND_ADD, 8'd0, tmse_pkg::WILD_RESET, 8'd50, 4'sd2, 8'd3,
                     8'h00, 8'h00),
                  ow(tmse_pkg::ST_DUP, 8'd0, 8'd0, 8'h00, 1'b0));
        add_row(mk(tmse_pkg::KIND_ADD, 8'd1, tmse_pkg::WILD_RESET, tmse_pkg::WILD_RESET, 4'sd7,
                   8'd2, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_ADD, 8'd2, 8'hff, 8'h00, -4'sd8, 8'd0, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_ADD, 8'd2, tmse_pkg::WILD_RESET, tmse_pkg::BLANK_CELL,
                   -4'sd1, 8'd0, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_ADD, 8'hff, 8'h00, 8'hff, 4'sd0, 8'hff, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_STEP, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_STEP, 8'hff, 8'hff, 8'hff, -4'sd1, 8'hff, 8'hff, 8'hff));
        add_row(mk(tmse_pkg::KIND_WRITE, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'd8, 8'hff));
        add_row(mk(tmse_pkg::KIND_STEP, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_STEP, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_STEP, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_STEP, 8'h00, 8'h00, 8'h00, 4'sd0, 8'h00, 8'h00, 8'h00));
        add_row(mk(tmse_pkg::KIND_READ, 8'hff, 8'hff, 8'hff, -4'sd1, 8'hff, 8'd1, 8'hff));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].ex);
        drain();

        halt_vals = '{8'd0, 8'd255, 8'd2, 8'd7, 8'd1, 8'd128, 8'd3, 8'd255};
        wild_vals = '{8'd0, 8'd255, 8'd95, 8'd48, 8'd49, 8'd95, 8'd50, 8'd95};
        for (int p = 0; p < 8; p++) begin
            if (p == 5) halt_vals[p] = 8'($urandom);
            if (p == 6) wild_vals[p] = 8'($urandom);
            write_cfg(tmse_pkg::CFG_HALT, halt_vals[p]);
            write_cfg(tmse_pkg::CFG_WILD, wild_vals[p]);
            no_gaps = (p % 3 == 1);
            allow_fault = (p == 7);
            for (int n = 0; n < 200; n++) begin
                w = rand_word();
                // keep the machine alive until the last phase
                if (!allow_fault && w.kind == tmse_pkg::KIND_STEP && step_faults())
                    w.kind = tmse_pkg::KIND_READ;
                send_word(w, 1'b0, '0);
            end
            drain();
        end

        repeat (80) @(posedge i_clk);
        if (pending_words.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("turing_machine_step_engine_top: match");
        end else begin
            $display("turing_machine_step_engine_top: mismatch");
        end
        $finish;
    end

endmodule
